// ----- src/mrt_pkg.sv -----
// Shared types and character constants for the record tokenizer.
`default_nettype none

package mrt_pkg;

  localparam int CLASS_LEN_DEF = 64;
  localparam int KEY_LEN_DEF   = 64;
  localparam int VALUE_LEN_DEF = 256;
  localparam int MAX_PAIRS_DEF = 32;

  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef enum logic [2:0] {
    PM_START  = 3'd0,
    PM_CLASS  = 3'd1,
    PM_KEY    = 3'd2,
    PM_VALUE  = 3'd3,
    PM_STRING = 3'd4,
    PM_ESCAPE = 3'd5,
    PM_DONE   = 3'd6
  } parse_mode_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_TYPE         = 4'd1,
    EV_CLASS_CHAR   = 4'd2,
    EV_CLASS_END    = 4'd3,
    EV_KEY_CHAR     = 4'd4,
    EV_KEY_END      = 4'd5,
    EV_VALUE_CHAR   = 4'd6,
    EV_PAIR_KEPT    = 4'd7,
    EV_PAIR_DROPPED = 4'd8,
    EV_LINE_DONE    = 4'd9
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic [7:0] pos;
    logic [5:0] slot;
  } result_t;

endpackage

`default_nettype wire

// ----- src/mi_record_tokenizer.sv -----
// Top level of the record tokenizer: parser state, result register and skid stage.
// Throughput: one request per cycle while the skid stage is empty.
// The parse state updates in the accepting cycle.
// A skid stage behind the result register keeps in_ready registered, so a request
// is still taken in the cycle that a stalled result is waiting.
// Reset (rst_n low, synchronous) returns the parser to waiting for a type mark,
// clears the counters and empties both result stages.
`default_nettype none

module mi_record_tokenizer #(
  parameter int CLASS_LEN = mrt_pkg::CLASS_LEN_DEF,
  parameter int KEY_LEN   = mrt_pkg::KEY_LEN_DEF,
  parameter int VALUE_LEN = mrt_pkg::VALUE_LEN_DEF,
  parameter int MAX_PAIRS = mrt_pkg::MAX_PAIRS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_line_first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_event_res,
  output logic [7:0]      out_byte_out,
  output logic [7:0]      out_position,
  output logic [5:0]      out_pair_index
);
  import mrt_pkg::*;

  localparam logic [7:0] CLASS_LIM = 8'(CLASS_LEN - 1);
  localparam logic [7:0] KEY_LIM   = 8'(KEY_LEN - 1);
  localparam logic [7:0] VALUE_LIM = 8'(VALUE_LEN - 1);
  localparam logic [5:0] PAIR_LIM  = 6'(MAX_PAIRS);

  parse_mode_t mode_r, mode_nxt, mode_eff;
  logic [7:0]  name_r, name_nxt, name_eff;
  logic [7:0]  value_r, value_nxt, value_eff;
  logic [5:0]  pairs_r, pairs_nxt, pairs_eff;

  result_t res;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    accept;
  logic    is_type_mark;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // The first byte of a line sees the parser as if freshly reset.
  assign mode_eff  = in_line_first ? PM_START : mode_r;
  assign name_eff  = in_line_first ? 8'd0 : name_r;
  assign value_eff = in_line_first ? 8'd0 : value_r;
  assign pairs_eff = in_line_first ? 6'd0 : pairs_r;

  assign is_type_mark = in_byte_in inside {CH_CARET, CH_STAR, CH_EQUALS, CH_TILDE, CH_AMP};

  // Next parser state.
  always_comb begin
    mode_nxt  = mode_eff;
    name_nxt  = name_eff;
    value_nxt = value_eff;
    pairs_nxt = pairs_eff;
    if (in_byte_in != CH_NUL) begin
      case (mode_eff)
        PM_START: begin
          if (is_type_mark) begin
            mode_nxt = PM_CLASS;
            name_nxt = 8'd0;
          end
        end
        PM_CLASS: begin
          if (in_byte_in == CH_COMMA) begin
            name_nxt = 8'd0;
            mode_nxt = PM_KEY;
          end else if (in_byte_in == CH_NEWLINE) begin
            mode_nxt = PM_DONE;
          end else if (name_eff < CLASS_LIM) begin
            name_nxt = name_eff + 8'd1;
          end
        end
        PM_KEY: begin
          if (in_byte_in == CH_EQUALS) begin
            name_nxt = 8'd0;
            mode_nxt = PM_VALUE;
          end else if (in_byte_in == CH_COMMA) begin
            name_nxt = 8'd0;
          end else if (name_eff < KEY_LIM) begin
            name_nxt = name_eff + 8'd1;
          end
        end
        PM_VALUE: begin
          // The value count restarts here, so an unquoted first byte is always taken.
          value_nxt = (in_byte_in == CH_QUOTE) ? 8'd0 : 8'd1;
          mode_nxt  = PM_STRING;
        end
        PM_STRING: begin
          if (in_byte_in == CH_BACKSLASH) begin
            mode_nxt = PM_ESCAPE;
          end else if (in_byte_in == CH_QUOTE || in_byte_in == CH_COMMA) begin
            if (pairs_eff < PAIR_LIM) begin
              pairs_nxt = pairs_eff + 6'd1;
            end
            mode_nxt = PM_KEY;
            name_nxt = 8'd0;
            if (in_byte_in == CH_COMMA) begin
              value_nxt = 8'd0;
            end
          end else if (value_eff < VALUE_LIM) begin
            value_nxt = value_eff + 8'd1;
          end
        end
        PM_ESCAPE: begin
          if (value_eff < VALUE_LIM) begin
            value_nxt = value_eff + 8'd1;
          end
          mode_nxt = PM_STRING;
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the current byte.
  always_comb begin
    res = '{ev: EV_NONE, ch: 8'd0, pos: 8'd0, slot: 6'd0};
    if (in_byte_in != CH_NUL) begin
      case (mode_eff)
        PM_START: begin
          if (is_type_mark) begin
            res.ev = EV_TYPE;
            res.ch = in_byte_in;
          end
        end
        PM_CLASS: begin
          if (in_byte_in == CH_COMMA) begin
            res.ev  = EV_CLASS_END;
            res.pos = name_eff;
          end else if (in_byte_in == CH_NEWLINE) begin
            res.ev  = EV_LINE_DONE;
            res.pos = name_eff;
          end else if (name_eff < CLASS_LIM) begin
            res.ev  = EV_CLASS_CHAR;
            res.ch  = in_byte_in;
            res.pos = name_eff;
          end
        end
        PM_KEY: begin
          if (in_byte_in == CH_EQUALS) begin
            res.ev  = EV_KEY_END;
            res.pos = name_eff;
          end else if (in_byte_in == CH_COMMA) begin
            res.ev = EV_NONE;
          end else if (name_eff < KEY_LIM) begin
            res.ev  = EV_KEY_CHAR;
            res.ch  = in_byte_in;
            res.pos = name_eff;
          end
        end
        PM_VALUE: begin
          if (in_byte_in != CH_QUOTE) begin
            res.ev = EV_VALUE_CHAR;
            res.ch = in_byte_in;
          end
        end
        PM_STRING: begin
          if (in_byte_in == CH_BACKSLASH) begin
            res.ev = EV_NONE;
          end else if (in_byte_in == CH_QUOTE || in_byte_in == CH_COMMA) begin
            res.ev   = (pairs_eff < PAIR_LIM) ? EV_PAIR_KEPT : EV_PAIR_DROPPED;
            res.pos  = value_eff;
            res.slot = pairs_eff;
          end else if (value_eff < VALUE_LIM) begin
            res.ev  = EV_VALUE_CHAR;
            res.ch  = in_byte_in;
            res.pos = value_eff;
          end
        end
        PM_ESCAPE: begin
          if (value_eff < VALUE_LIM) begin
            res.ev  = EV_VALUE_CHAR;
            res.ch  = in_byte_in;
            res.pos = value_eff;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= PM_START;
      name_r  <= 8'd0;
      value_r <= 8'd0;
      pairs_r <= 6'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      name_r  <= name_nxt;
      value_r <= value_nxt;
      pairs_r <= pairs_nxt;
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res;
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_r.ev;
  assign out_byte_out   = out_r.ch;
  assign out_position   = out_r.pos;
  assign out_pair_index = out_r.slot;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a request while the result register is empty");

  a_pair_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pairs_r <= PAIR_LIM)
    else $error("pair count beyond the pair limit");

  a_kept_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ev == EV_PAIR_KEPT) |-> (out_r.slot < PAIR_LIM))
    else $error("kept pair reported in a slot beyond the pair limit");

  a_line_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.ev == EV_LINE_DONE) |=> (mode_r == PM_DONE))
    else $error("newline in the class name did not close the line");
`endif

endmodule

`default_nettype wire
